// ===== rtl/core/i2cts_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cts_pkg
// Shared types and constants for the I2C target bus sampler.
// ----------------------------------------------------------------------------
package i2cts_pkg;

	// Byte counter width; byte_index shows its low eight bits
	localparam int IDX_W = 8;

	// Configuration register widths and indexes
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESENT_LOW  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESENT_HIGH = 1'b1;

	// Bit phase codes: idle, first bit slot, ack slot
	localparam logic [3:0] PH_IDLE  = 4'd0;
	localparam logic [3:0] PH_FIRST = 4'd1;
	localparam logic [3:0] PH_ACK   = 4'd9;

	// Byte shifted out for an absent target
	localparam logic [7:0] ABSENT_BYTE = 8'hff;

	// Input sample, lowest field in the lowest bits
	typedef struct packed {
		logic       write_ok;
		logic [7:0] read_data;
		logic       sda;
		logic       scl;
	} item_t;

	// Result, lowest field in the lowest bits
	typedef struct packed {
		logic [7:0] write_data;
		logic [7:0] byte_index;
		logic [6:0] target_addr;
		logic       write_req;
		logic       read_req;
		logic       sda_drive;
	} result_t;

	localparam int ITEM_W   = $bits(item_t);
	localparam int RESULT_W = $bits(result_t);
	localparam int S_DATA_W = ((ITEM_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

// ===== rtl/core/i2cts_in_reg.sv =====
// ----------------------------------------------------------------------------
// i2cts_in_reg
// Input register: holds one line sample until the update logic takes it.
// ----------------------------------------------------------------------------
module i2cts_in_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  i2cts_pkg::item_t      s_item,
	input  logic                  out_ready,
	output logic                  valid_s1,
	output i2cts_pkg::item_t      item_s1
);

	// Free when empty or when the held sample moves on this cycle
	assign s_tready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (out_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= s_item;
		end
	end

endmodule

// ===== rtl/core/i2cts_core.sv =====
// ----------------------------------------------------------------------------
// i2cts_core
// Bus state, presence map and the single-pass update for one line sample.
// ----------------------------------------------------------------------------
module i2cts_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [i2cts_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [i2cts_pkg::CFG_W-1:0]          cfg_wdata,
	input  logic                                 step,
	input  i2cts_pkg::item_t                     item,
	output i2cts_pkg::result_t                   result
);

	logic [i2cts_pkg::CFG_W-1:0] present_low_q;
	logic [i2cts_pkg::CFG_W-1:0] present_high_q;

	logic                        last_clock_q;
	logic                        last_data_q;
	logic                        last_drive_q;
	logic [3:0]                  phase_q;
	logic [i2cts_pkg::IDX_W-1:0] cnt_q;
	logic                        reading_q;
	logic [7:0]                  shift_q;
	logic [7:0]                  addr_q;

	logic                        drive_n;
	logic [3:0]                  phase_n;
	logic [i2cts_pkg::IDX_W-1:0] cnt_n;
	logic                        reading_n;
	logic [7:0]                  shift_n;
	logic [7:0]                  addr_n;

	logic [127:0]                pmap;
	logic                        pres_cur;
	logic                        pres_new;
	logic                        is_stop;
	logic                        is_start;
	logic                        is_rise;
	logic [7:0]                  rd_byte;
	logic                        rreq;
	logic                        wreq;
	logic [7:0]                  wdata;
	logic                        idx_pre;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_low_q  <= '0;
			present_high_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				i2cts_pkg::CFG_PRESENT_LOW:  present_low_q  <= cfg_wdata;
				i2cts_pkg::CFG_PRESENT_HIGH: present_high_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Presence lookups for the held address and a freshly received one
	assign pmap     = {present_high_q, present_low_q};
	assign pres_cur = pmap[addr_q[7:1]];
	assign pres_new = pmap[shift_q[7:1]];

	// Bus conditions from previous and current levels
	assign is_stop  = last_clock_q && item.scl && !last_data_q && item.sda;
	assign is_start = last_clock_q && item.scl && last_data_q && !item.sda;
	assign is_rise  = !last_clock_q && item.scl && (last_data_q == item.sda) &&
	                  (phase_q != i2cts_pkg::PH_IDLE);

	// Byte to shift out: fetched at the first slot, else the shifter
	always_comb begin
		if (phase_q == i2cts_pkg::PH_FIRST) begin
			rd_byte = pres_cur ? item.read_data : i2cts_pkg::ABSENT_BYTE;
		end else begin
			rd_byte = shift_q;
		end
	end

	// Next state and result fields
	always_comb begin
		drive_n   = last_drive_q;
		phase_n   = phase_q;
		cnt_n     = cnt_q;
		reading_n = reading_q;
		shift_n   = shift_q;
		addr_n    = addr_q;
		rreq      = 1'b0;
		wreq      = 1'b0;
		wdata     = 8'h00;
		idx_pre   = 1'b0;
		if (is_stop) begin
			phase_n = i2cts_pkg::PH_IDLE;
			drive_n = 1'b1;
		end else if (is_start) begin
			phase_n   = i2cts_pkg::PH_FIRST;
			cnt_n     = '0;
			reading_n = 1'b0;
			drive_n   = 1'b1;
		end else if (is_rise) begin
			drive_n = 1'b1;
			if (reading_q) begin
				if (phase_q != i2cts_pkg::PH_ACK) begin
					// read bit slot: MSB first, absent target sends ones
					rreq    = (phase_q == i2cts_pkg::PH_FIRST) && pres_cur;
					drive_n = rd_byte[7];
					shift_n = {rd_byte[6:0], 1'b0};
					phase_n = phase_q + 4'd1;
				end else begin
					// master ack slot, not checked
					cnt_n   = cnt_q + i2cts_pkg::IDX_W'(1);
					phase_n = i2cts_pkg::PH_FIRST;
				end
			end else begin
				if (phase_q != i2cts_pkg::PH_ACK) begin
					shift_n = {shift_q[6:0], item.sda};
					phase_n = phase_q + 4'd1;
				end else begin
					// ack slot: address byte, or write byte to the device
					if (cnt_q == '0) begin
						addr_n = shift_q;
						if (shift_q[0]) begin
							reading_n = 1'b1;
						end
						drive_n = !pres_new;
					end else if (pres_cur) begin
						wreq    = 1'b1;
						wdata   = shift_q;
						drive_n = !item.write_ok;
					end else begin
						drive_n = 1'b1;
					end
					idx_pre = 1'b1;
					cnt_n   = cnt_q + i2cts_pkg::IDX_W'(1);
					phase_n = i2cts_pkg::PH_FIRST;
				end
			end
		end
	end

	always_comb begin
		result.sda_drive   = drive_n;
		result.read_req    = rreq;
		result.write_req   = wreq;
		result.target_addr = addr_n[7:1];
		result.byte_index  = idx_pre ? 8'(cnt_q) : 8'(cnt_n);
		result.write_data  = wdata;
	end

	// State update, one sample per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_clock_q <= 1'b0;
			last_data_q  <= 1'b0;
			last_drive_q <= 1'b0;
			phase_q      <= i2cts_pkg::PH_IDLE;
			cnt_q        <= '0;
			reading_q    <= 1'b0;
			shift_q      <= 8'h00;
			addr_q       <= 8'h00;
		end else if (step) begin
			last_clock_q <= item.scl;
			last_data_q  <= item.sda;
			last_drive_q <= drive_n;
			phase_q      <= phase_n;
			cnt_q        <= cnt_n;
			reading_q    <= reading_n;
			shift_q      <= shift_n;
			addr_q       <= addr_n;
		end
	end

endmodule

// ===== rtl/core/i2cts_out_reg.sv =====
// ----------------------------------------------------------------------------
// i2cts_out_reg
// Result register on the master side; the update logic stalls while it waits.
// ----------------------------------------------------------------------------
module i2cts_out_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  i2cts_pkg::result_t    result,
	output logic                  out_ready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output i2cts_pkg::result_t    result_s2
);

	// Can take a result when empty or when the held one leaves now
	assign out_ready = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (load) begin
			result_s2 <= result;
		end
	end

endmodule

// ===== rtl/core/i2c_target_bus_sampler.sv =====
// ----------------------------------------------------------------------------
// i2c_target_bus_sampler
// Bit-level I2C target working on sampled SCL/SDA levels.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one sample of SCL and SDA per transaction, along with the
//   device's read byte and write acceptance. m_* returns one result per
//   sample: the SDA drive level, read/write request strobes, the target
//   address, the byte index and the received write byte.
//   cfg_we/cfg_idx/cfg_wdata load the 128-bit presence map as two 64-bit
//   registers; write them only while no sample is in flight.
//   Throughput: one sample per cycle while m_tready is high; each sample
//   passes an input register, a single bus update pass and a result register.
//   Reset clears the bus state, the presence map and the valid flags of both
//   registers; the first result after reset always drives SDA low.
//   When m_tready is low the result is held, one more sample is taken into
//   the input register if it is empty, and s_tready stays low until the
//   result leaves.
// ----------------------------------------------------------------------------
module i2c_target_bus_sampler (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [i2cts_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [i2cts_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// scl[0], sda[1], read_data[9:2], write_ok[10], zero fill
	input  logic [i2cts_pkg::S_DATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// sda_drive[0], read_req[1], write_req[2], target_addr[9:3],
	// byte_index[17:10], write_data[25:18], zero fill
	output logic [i2cts_pkg::M_DATA_W-1:0]      m_tdata
);

	i2cts_pkg::item_t   s_item;
	i2cts_pkg::item_t   item_s1;
	i2cts_pkg::result_t result;
	i2cts_pkg::result_t result_s2;
	logic               valid_s1;
	logic               out_ready;
	logic               step;

	assign s_item = i2cts_pkg::item_t'(s_tdata[i2cts_pkg::ITEM_W-1:0]);
	assign step   = valid_s1 && out_ready;

	i2cts_in_reg u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_item    (s_item),
		.out_ready (out_ready),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	i2cts_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.step      (step),
		.item      (item_s1),
		.result    (result)
	);

	i2cts_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step),
		.result    (result),
		.out_ready (out_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.result_s2 (result_s2)
	);

	assign m_tdata = {{(i2cts_pkg::M_DATA_W - i2cts_pkg::RESULT_W){1'b0}}, result_s2};

endmodule

// ===== rtl/core/i2cts_checker.sv =====
// ----------------------------------------------------------------------------
// i2cts_checker
// Port-level checks for the I2C target bus sampler, bound to the top level.
// ----------------------------------------------------------------------------
module i2cts_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tready,
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic [i2cts_pkg::M_DATA_W-1:0]      m_tdata
);

	i2cts_pkg::result_t res;
	assign res = i2cts_pkg::result_t'(m_tdata[i2cts_pkg::RESULT_W-1:0]);

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// With the result side empty the input side must be open
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	// A sample never both reads from and writes to the device
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(res.read_req && res.write_req))
		else $error("read and write request in one result");

	// Write byte is zero unless a write is requested
	a_wdata: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res.write_req |-> res.write_data == 8'h00)
		else $error("write data without write request");

endmodule

bind i2c_target_bus_sampler i2cts_checker u_checker (.*);

// ===== tb/sv/i2c_sampler_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_sampler_checker
// Watches the sample and result streams of the I2C target bus sampler. Keeps
// its own copy of the bus state and presence map, predicts one result for
// every accepted sample, and compares each returned result field by field.
// ----------------------------------------------------------------------------
module i2c_sampler_checker
	import i2cts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_DATA_W-1:0]  s_tdata,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_DATA_W-1:0]  m_tdata,
	output int                   mismatches,
	output int                   outstanding
);

	// Presence map and bus state of the predictor
	logic [CFG_W-1:0] map_lo, map_hi;
	logic             prev_scl, prev_sda, prev_drive;
	logic [3:0]       phase;
	logic [IDX_W-1:0] byte_cnt;
	logic             rd_mode;
	logic [7:0]       shreg;
	logic [7:0]       addr_byte;

	result_t pending_results[$];
	result_t got, want;

	// Presence bit of the currently latched target
	function automatic logic addr_present();
		logic [2*CFG_W-1:0] map;
		map = {map_hi, map_lo};
		return map[addr_byte[7:1]];
	endfunction

	// Advance the bus state by one line sample, return the result it causes
	function automatic result_t step_target(item_t smp);
		result_t r;
		logic    drv;
		logic    acked;
		r     = '0;
		drv   = prev_drive;
		acked = 1'b0;
		if (prev_scl && smp.scl && !prev_sda && smp.sda) begin
			// stop condition
			phase = PH_IDLE;
			drv   = 1'b1;
		end else if (prev_scl && smp.scl && prev_sda && !smp.sda) begin
			// start or repeated start
			phase    = PH_FIRST;
			byte_cnt = '0;
			rd_mode  = 1'b0;
			drv      = 1'b1;
		end else if (!prev_scl && smp.scl && prev_sda == smp.sda && phase != PH_IDLE) begin
			drv = 1'b1;
			if (rd_mode) begin
				if (phase != PH_ACK) begin
					// fetch on the first slot, then shift out MSB first
					if (phase == PH_FIRST) begin
						if (addr_present()) begin
							shreg      = smp.read_data;
							r.read_req = 1'b1;
						end else begin
							shreg = ABSENT_BYTE;
						end
					end
					drv   = shreg[7];
					shreg = shreg << 1;
					phase = phase + 4'd1;
				end else begin
					// master ack is ignored
					byte_cnt = byte_cnt + 1'b1;
					phase    = PH_FIRST;
				end
			end else if (phase != PH_ACK) begin
				shreg = {shreg[6:0], smp.sda};
				phase = phase + 4'd1;
			end else begin
				// ack slot of an address or write byte
				if (byte_cnt == '0) begin
					addr_byte = shreg;
					if (shreg[0])
						rd_mode = 1'b1;
					drv = !addr_present();
				end else if (addr_present()) begin
					r.write_req  = 1'b1;
					r.write_data = shreg;
					drv          = !smp.write_ok;
				end else begin
					drv = 1'b1;
				end
				r.byte_index = byte_cnt[7:0];
				acked        = 1'b1;
				byte_cnt     = byte_cnt + 1'b1;
				phase        = PH_FIRST;
			end
		end
		if (!acked)
			r.byte_index = byte_cnt[7:0];
		prev_scl      = smp.scl;
		prev_sda      = smp.sda;
		prev_drive    = drv;
		r.sda_drive   = drv;
		r.target_addr = addr_byte[7:1];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got_v,
			input logic [31:0] exp_v);
		$display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got_v, exp_v);
		mismatches++;
	endtask

	// Track configuration, predict on accepted samples, check accepted results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_lo      = '0;
			map_hi      = '0;
			prev_scl    = 1'b0;
			prev_sda    = 1'b0;
			prev_drive  = 1'b0;
			phase       = PH_IDLE;
			byte_cnt    = '0;
			rd_mode     = 1'b0;
			shreg       = '0;
			addr_byte   = '0;
			mismatches  = 0;
			outstanding = 0;
			pending_results.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_PRESENT_LOW: map_lo = cfg_wdata;
					CFG_PRESENT_HIGH: map_hi = cfg_wdata;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[RESULT_W-1:0];
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result", 32'(got), '0);
				end else begin
					want = pending_results.pop_front();
					if (got.sda_drive !== want.sda_drive)
						report_mismatch("sda_drive", 32'(got.sda_drive),
							32'(want.sda_drive));
					if (got.read_req !== want.read_req)
						report_mismatch("read_req", 32'(got.read_req),
							32'(want.read_req));
					if (got.write_req !== want.write_req)
						report_mismatch("write_req", 32'(got.write_req),
							32'(want.write_req));
					if (got.target_addr !== want.target_addr)
						report_mismatch("target_addr", 32'(got.target_addr),
							32'(want.target_addr));
					if (got.byte_index !== want.byte_index)
						report_mismatch("byte_index", 32'(got.byte_index),
							32'(want.byte_index));
					if (got.write_data !== want.write_data)
						report_mismatch("write_data", 32'(got.write_data),
							32'(want.write_data));
				end
			end
			if (s_tvalid && s_tready)
				pending_results.push_back(step_target(s_tdata[ITEM_W-1:0]));
			outstanding = pending_results.size();
		end
	end

endmodule

// ===== tb/sv/tb_i2c_target_bus_sampler.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_i2c_target_bus_sampler
// Drives sampled SCL/SDA traffic into the bus sampler: a few hand-picked
// samples, then mostly well-formed transfers with random addresses, data and
// truncation, mixed with line noise, under several pacing and presence-map
// settings. Checking is done by the checker instance; this module only makes
// stimulus and gives a verdict.
// ----------------------------------------------------------------------------
module tb_i2c_target_bus_sampler;
	import i2cts_pkg::*;

	localparam int HOLD_CYCLES = 64;
	localparam int DRAIN_LIMIT = 20000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_wdata;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_DATA_W-1:0]  m_tdata;

	int mismatches;
	int outstanding;
	int idle_pct;
	int stall_pct;
	int hold_reqs;
	int hold_seen;
	int hold_left;
	int phase_sent;

	always #5 clk = ~clk;

	i2c_target_bus_sampler i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	i2c_sampler_checker i_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Result side: random stalls, plus a long hold-off when requested
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Run limit
	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	// One sample transaction, with random idle cycles in front
	task automatic send_sample(input logic scl, input logic sda, input logic [7:0] rdata,
			input logic wok);
		item_t smp;
		smp.scl       = scl;
		smp.sda       = sda;
		smp.read_data = rdata;
		smp.write_ok  = wok;
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_DATA_W'(smp);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		phase_sent++;
	endtask

	task automatic drive_lines(input logic scl, input logic sda);
		send_sample(scl, sda, 8'($urandom_range(255)), 1'($urandom_range(1)));
	endtask

	// One clock pulse on the bus, sometimes with a held level on either side
	task automatic send_bit(input logic b);
		drive_lines(1'b0, b);
		if ($urandom_range(4) == 0)
			drive_lines(1'b0, b);
		drive_lines(1'b1, b);
		if ($urandom_range(4) == 0)
			drive_lines(1'b1, b);
	endtask

	task automatic stop_cond();
		drive_lines(1'b0, 1'b0);
		drive_lines(1'b1, 1'b0);
		drive_lines(1'b1, 1'b1);
	endtask

	// Start, address byte, data bytes, each with an ack slot; optionally cut
	// short, and ended by a stop or left open for a repeated start
	task automatic run_transfer(input logic [6:0] addr, input logic rd, input int nbytes,
			input logic cut, input logic stop);
		logic       bits_q[$];
		logic [7:0] v;
		int         keep;
		v = {addr, rd};
		for (int i = 7; i >= 0; i--)
			bits_q.push_back(v[i]);
		bits_q.push_back(1'($urandom_range(1)));
		repeat (nbytes) begin
			v = 8'($urandom_range(255));
			for (int i = 7; i >= 0; i--)
				bits_q.push_back(v[i]);
			bits_q.push_back(1'($urandom_range(1)));
		end
		if (cut) begin
			keep = $urandom_range(1, bits_q.size() - 1);
			while (bits_q.size() > keep)
				void'(bits_q.pop_back());
		end
		drive_lines(1'b0, 1'b1);
		drive_lines(1'b1, 1'b1);
		drive_lines(1'b1, 1'b0);
		foreach (bits_q[i])
			send_bit(bits_q[i]);
		if (stop || cut)
			stop_cond();
	endtask

	// Mostly transfers, some bursts of raw line noise
	task automatic random_traffic(input int quota);
		phase_sent = 0;
		while (phase_sent < quota) begin
			if ($urandom_range(99) < 12) begin
				repeat ($urandom_range(1, 6))
					drive_lines(1'($urandom_range(1)), 1'($urandom_range(1)));
			end else begin
				run_transfer(7'($urandom_range(127)), 1'($urandom_range(1)),
					$urandom_range(3), $urandom_range(99) < 10, $urandom_range(99) >= 25);
			end
		end
	endtask

	// Wait until every accepted sample has returned its result
	task automatic drain_results();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		do begin
			@(negedge clk);
			waited++;
		end while (outstanding != 0 && waited < DRAIN_LIMIT);
		@(posedge clk);
	endtask

	task automatic load_map(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
		cfg_we    <= 1'b1;
		cfg_idx   <= CFG_PRESENT_LOW;
		cfg_wdata <= lo;
		@(posedge clk);
		cfg_idx   <= CFG_PRESENT_HIGH;
		cfg_wdata <= hi;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_pacing(input int idle, input int stall);
		idle_pct = idle;
		stall_pct <= stall;
	endtask

	initial begin
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_idx   <= CFG_PRESENT_LOW;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		hold_reqs <= 0;
		idle_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Hand-picked samples: drive held low after reset, clock rise while
		// idle, stop, start, clock rise with SDA moving, repeated start
		load_map('1, '0);
		set_pacing(0, 0);
		send_sample(1'b0, 1'b0, 8'h00, 1'b0);
		send_sample(1'b1, 1'b0, 8'hff, 1'b1);
		send_sample(1'b1, 1'b1, 8'h00, 1'b1);
		send_sample(1'b1, 1'b0, 8'hff, 1'b0);
		send_sample(1'b0, 1'b0, 8'h00, 1'b1);
		send_sample(1'b1, 1'b1, 8'hff, 1'b0);
		send_sample(1'b0, 1'b1, 8'h00, 1'b0);
		send_sample(1'b1, 1'b1, 8'hff, 1'b1);
		send_sample(1'b1, 1'b1, 8'h00, 1'b0);
		send_sample(1'b0, 1'b1, 8'hff, 1'b1);
		send_sample(1'b1, 1'b1, 8'h00, 1'b1);
		send_sample(1'b1, 1'b0, 8'hff, 1'b0);
		send_sample(1'b0, 1'b0, 8'h00, 1'b0);
		send_sample(1'b1, 1'b0, 8'hff, 1'b1);
		send_sample(1'b1, 1'b1, 8'h00, 1'b0);
		send_sample(1'b1, 1'b1, 8'hff, 1'b1);
		random_traffic(60);
		drain_results();

		// Random map, sender idling
		load_map({$urandom, $urandom}, {$urandom, $urandom});
		set_pacing(55, 0);
		random_traffic(60);
		drain_results();

		// Upper half present, receiver stalling
		load_map('0, '1);
		set_pacing(0, 55);
		random_traffic(60);
		drain_results();

		// Random map, both sides idling
		load_map({$urandom, $urandom}, {$urandom, $urandom});
		set_pacing(19, 19);
		random_traffic(60);
		drain_results();

		// Receiver holds off while samples keep coming, so the input backs up
		load_map('1, '1);
		set_pacing(0, 0);
		hold_reqs <= hold_reqs + 1;
		random_traffic(40);
		drain_results();

		// Nothing present
		load_map('0, '0);
		set_pacing(19, 19);
		random_traffic(30);
		drain_results();

		repeat (4) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== i2c_target_bus_sampler.f =====
rtl/core/i2cts_pkg.sv
rtl/core/i2cts_in_reg.sv
rtl/core/i2cts_core.sv
rtl/core/i2cts_out_reg.sv
rtl/core/i2c_target_bus_sampler.sv
rtl/core/i2cts_checker.sv
tb/sv/i2c_sampler_checker.sv
tb/sv/tb_i2c_target_bus_sampler.sv
